// ===== hw/rtl/rpp_pkg.sv =====
package rpp_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned SLIDER_W   = 12;
  localparam int unsigned PCT_W      = 9;

  localparam logic [SEL_W-1:0] NUM_PATTERNS = 2'd3;

  // serial arithmetic unit
  localparam int unsigned ALU_W = 23;
  localparam int unsigned DVS_W = 12;
  localparam int unsigned MPL_W = 9;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] MUL_STEPS = 5'd9;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd23;

  localparam logic [DVS_W-1:0] SLIDER_FULL = 12'd4095;
  localparam logic [DVS_W-1:0] PCT_SCALE   = 12'd100;

  // register reset values
  localparam logic [9:0]  BASE_TICK_RST = 10'd100;
  localparam logic [8:0]  TEMPO_MIN_RST = 9'd40;
  localparam logic [8:0]  TEMPO_MAX_RST = 9'd180;
  localparam logic [9:0]  MIN_STEP_RST  = 10'd30;
  localparam logic [9:0]  DEBOUNCE_RST  = 10'd50;
  localparam logic [13:0] GAP_RST       = 14'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_TICK = 3'd0,
    CFG_TEMPO_MIN = 3'd1,
    CFG_TEMPO_MAX = 3'd2,
    CFG_MIN_STEP  = 3'd3,
    CFG_DEBOUNCE  = 3'd4,
    CFG_GAP       = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [ALU_W-1:0] opa;
    logic [DVS_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [ALU_W-1:0] result;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BTN,
    S_PLAY,
    S_MUL_TEMPO,
    S_DIV_TEMPO,
    S_MUL_BASE,
    S_MUL_UNITS,
    S_DIV_DUR,
    S_EMIT
  } state_t;

  // step word: bit 4 = sound on, bits 3:0 = length in units, zero marks the end
  localparam logic [4:0] ON1  = 5'h11;
  localparam logic [4:0] ON3  = 5'h13;
  localparam logic [4:0] OFF1 = 5'h01;
  localparam logic [4:0] OFF2 = 5'h02;
  localparam logic [4:0] OFF3 = 5'h03;
  localparam logic [4:0] OFF4 = 5'h04;
  localparam logic [4:0] STEP_END = 5'h00;

  function automatic logic [4:0] rom_entry(input logic [SEL_W-1:0] sel,
                                           input logic [POS_W-1:0] pos);
    logic [4:0] e;
    e = STEP_END;
    case (sel)
      2'd0: begin
        case (pos)
          5'd0, 5'd2, 5'd6, 5'd8:   e = ON1;
          5'd1, 5'd3, 5'd7, 5'd9:   e = OFF1;
          5'd4, 5'd10:              e = ON3;
          5'd5, 5'd11:              e = OFF4;
          default:                  e = STEP_END;
        endcase
      end
      2'd1: begin
        case (pos)
          5'd0, 5'd2, 5'd6, 5'd8, 5'd12:  e = ON1;
          5'd1, 5'd7:                     e = OFF1;
          5'd3, 5'd9, 5'd13, 5'd15:       e = OFF2;
          5'd4, 5'd10, 5'd14, 5'd16:      e = ON3;
          5'd5, 5'd11:                    e = OFF3;
          5'd17:                          e = OFF4;
          default:                        e = STEP_END;
        endcase
      end
      2'd2: begin
        case (pos)
          5'd0, 5'd2, 5'd4, 5'd8, 5'd10, 5'd12: e = ON1;
          5'd1, 5'd3, 5'd5, 5'd9, 5'd11, 5'd13: e = OFF1;
          5'd6, 5'd14:                          e = ON3;
          5'd7:                                 e = OFF2;
          5'd15:                                e = OFF3;
          default:                              e = STEP_END;
        endcase
      end
      default: e = STEP_END;
    endcase
    return e;
  endfunction

  // LED set for a phase, as {green, yellow, red}
  function automatic logic [2:0] phase_leds(input logic [1:0] phase);
    logic [2:0] l;
    case (phase)
      2'd0:    l = 3'b001;
      2'd1:    l = 3'b010;
      2'd2:    l = 3'b100;
      default: l = 3'b111;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/rhythm_pattern_player_top.sv =====
// A poll that plays no new step passes S_BTN, S_PLAY and S_EMIT before its word is
// registered; one that plays a step also runs the bit-serial unit in between: a multiply
// and a divide for the tempo (skipped when tempo min is above max), then a multiply by
// the base tick, one by the units and a divide by 100. One poll at a time, taken only in
// S_IDLE; a stalled output word holds the next poll back. Reset (rst_n low, synchronous)
// restores register defaults, selects pattern 0 at step 0, disarms, clears out_valid.
module rhythm_pattern_player_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_time_now,
  input  logic        in_raw_restart,
  input  logic        in_raw_next,
  input  logic [11:0] in_slider_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_buzzer,
  output logic        out_led_red,
  output logic        out_led_yellow,
  output logic        out_led_green,
  output logic [1:0]  out_pattern_now,
  output logic [4:0]  out_step_now,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  rpp_pkg::state_t state_r, state_nxt;

  logic [9:0]  base_r;
  logic [8:0]  tmin_r;
  logic [8:0]  tmax_r;
  logic [9:0]  minstep_r;
  logic [9:0]  deb_r;
  logic [13:0] gap_r;

  logic [31:0] t_r, t_nxt;
  logic [11:0] slider_r, slider_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        fin_r, fin_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic        armed_r, armed_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  drive_r, drive_nxt;
  logic [3:0]  units_r, units_nxt;

  logic        out_valid_r;
  logic [3:0]  out_drive_r;
  logic [1:0]  out_sel_r;
  logic [4:0]  out_pos_r;
  logic        out_load;

  logic        accept;
  logic        press_restart;
  logic        press_next;

  rpp_pkg::alu_req_t alu_req;
  rpp_pkg::alu_rsp_t alu_rsp;

  logic [22:0] sat_addend_c;
  logic [32:0] sat_sum_c;
  logic [31:0] sat_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == rpp_pkg::S_IDLE);

  rpp_debounce u_db_restart (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (accept),
    .raw    (in_raw_restart),
    .t      (in_time_now),
    .deb_ms (deb_r),
    .press  (press_restart)
  );

  rpp_debounce u_db_next (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (accept),
    .raw    (in_raw_next),
    .t      (in_time_now),
    .deb_ms (deb_r),
    .press  (press_next)
  );

  rpp_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // saturating deadline adder, shared by the gap and the step length
  assign sat_sum_c = {1'b0, t_r} + {10'd0, sat_addend_c};
  assign sat_c     = sat_sum_c[32] ? 32'hFFFF_FFFF : sat_sum_c[31:0];

  always_comb begin
    logic [4:0]  entry;
    logic [2:0]  idx_inc;
    logic [1:0]  idx;
    logic [8:0]  tempo;
    logic [22:0] dur;

    entry   = rpp_pkg::rom_entry(sel_r, pos_r);
    idx_inc = {1'b0, sel_r} + 3'd1;
    idx     = (idx_inc >= {1'b0, rpp_pkg::NUM_PATTERNS}) ?
              2'(idx_inc - {1'b0, rpp_pkg::NUM_PATTERNS}) : idx_inc[1:0];
    tempo   = tmax_r - alu_rsp.result[8:0];
    dur     = (alu_rsp.result < {13'd0, minstep_r}) ? {13'd0, minstep_r} : alu_rsp.result;

    state_nxt  = state_r;
    t_nxt      = t_r;
    slider_nxt = slider_r;
    sel_nxt    = sel_r;
    pos_nxt    = pos_r;
    fin_nxt    = fin_r;
    dl_nxt     = dl_r;
    armed_nxt  = armed_r;
    phase_nxt  = phase_r;
    drive_nxt  = drive_r;
    units_nxt  = units_r;
    out_load   = 1'b0;
    sat_addend_c = {9'd0, gap_r};
    alu_req.start = 1'b0;
    alu_req.op    = rpp_pkg::ALU_MUL;
    alu_req.opa   = '0;
    alu_req.opb   = '0;

    case (state_r)
      rpp_pkg::S_IDLE: begin
        if (in_valid) begin
          t_nxt      = in_time_now;
          slider_nxt = in_slider_sample;
          state_nxt  = rpp_pkg::S_BTN;
        end
      end

      rpp_pkg::S_BTN: begin
        // next wins over restart: restart keeps the pattern, next then moves it
        if (press_next || press_restart) begin
          if (press_next) begin
            sel_nxt = (idx >= rpp_pkg::NUM_PATTERNS) ? 2'd0 : idx;
          end else begin
            sel_nxt = (sel_r >= rpp_pkg::NUM_PATTERNS) ? 2'd0 : sel_r;
          end
          pos_nxt   = '0;
          fin_nxt   = 1'b0;
          phase_nxt = '0;
          dl_nxt    = '0;
          armed_nxt = 1'b0;
        end
        state_nxt = rpp_pkg::S_PLAY;
      end

      rpp_pkg::S_PLAY: begin
        state_nxt = rpp_pkg::S_EMIT;
        if (fin_r) begin
          drive_nxt = '0;
          if (!armed_r) begin
            dl_nxt    = sat_c;
            armed_nxt = 1'b1;
          end else if (t_r >= dl_r) begin
            pos_nxt   = '0;
            fin_nxt   = 1'b0;
            phase_nxt = '0;
            dl_nxt    = '0;
            armed_nxt = 1'b0;
          end
        end else if (!(armed_r && (t_r < dl_r))) begin
          if (entry[3:0] == 4'd0) begin
            fin_nxt   = 1'b1;
            dl_nxt    = '0;
            armed_nxt = 1'b0;
            drive_nxt = '0;
          end else begin
            if (entry[4]) begin
              drive_nxt = {rpp_pkg::phase_leds(phase_r), 1'b1};
              phase_nxt = phase_r + 2'd1;
            end else begin
              drive_nxt = '0;
            end
            units_nxt = entry[3:0];
            pos_nxt   = pos_r + 5'd1;
            alu_req.start = 1'b1;
            alu_req.op    = rpp_pkg::ALU_MUL;
            if (tmax_r >= tmin_r) begin
              alu_req.opa = {11'd0, slider_r};
              alu_req.opb = {3'd0, tmax_r - tmin_r};
              state_nxt   = rpp_pkg::S_MUL_TEMPO;
            end else begin
              // inverted range: the clamps always settle on tempo max
              alu_req.opa = {13'd0, base_r};
              alu_req.opb = {3'd0, tmax_r};
              state_nxt   = rpp_pkg::S_MUL_BASE;
            end
          end
        end
      end

      rpp_pkg::S_MUL_TEMPO: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpp_pkg::ALU_DIV;
          alu_req.opa   = alu_rsp.result;
          alu_req.opb   = rpp_pkg::SLIDER_FULL;
          state_nxt     = rpp_pkg::S_DIV_TEMPO;
        end
      end

      rpp_pkg::S_DIV_TEMPO: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpp_pkg::ALU_MUL;
          alu_req.opa   = {13'd0, base_r};
          alu_req.opb   = {3'd0, tempo};
          state_nxt     = rpp_pkg::S_MUL_BASE;
        end
      end

      rpp_pkg::S_MUL_BASE: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpp_pkg::ALU_MUL;
          alu_req.opa   = alu_rsp.result;
          alu_req.opb   = {8'd0, units_r};
          state_nxt     = rpp_pkg::S_MUL_UNITS;
        end
      end

      rpp_pkg::S_MUL_UNITS: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = rpp_pkg::ALU_DIV;
          alu_req.opa   = alu_rsp.result;
          alu_req.opb   = rpp_pkg::PCT_SCALE;
          state_nxt     = rpp_pkg::S_DIV_DUR;
        end
      end

      rpp_pkg::S_DIV_DUR: begin
        sat_addend_c = dur;
        if (alu_rsp.done) begin
          dl_nxt    = sat_c;
          armed_nxt = 1'b1;
          state_nxt = rpp_pkg::S_EMIT;
        end
      end

      rpp_pkg::S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = rpp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rpp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpp_pkg::S_IDLE;
      sel_r       <= '0;
      pos_r       <= '0;
      fin_r       <= 1'b0;
      dl_r        <= '0;
      armed_r     <= 1'b0;
      phase_r     <= '0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      dl_r    <= dl_nxt;
      armed_r <= armed_nxt;
      phase_r <= phase_nxt;
      drive_r <= drive_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    slider_r <= slider_nxt;
    units_r  <= units_nxt;
    if (out_load) begin
      out_drive_r <= drive_r;
      out_sel_r   <= sel_r;
      out_pos_r   <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= rpp_pkg::BASE_TICK_RST;
      tmin_r    <= rpp_pkg::TEMPO_MIN_RST;
      tmax_r    <= rpp_pkg::TEMPO_MAX_RST;
      minstep_r <= rpp_pkg::MIN_STEP_RST;
      deb_r     <= rpp_pkg::DEBOUNCE_RST;
      gap_r     <= rpp_pkg::GAP_RST;
    end else if (cfg_we) begin
      case (rpp_pkg::cfg_idx_t'(cfg_index))
        rpp_pkg::CFG_BASE_TICK: base_r    <= cfg_wdata[9:0];
        rpp_pkg::CFG_TEMPO_MIN: tmin_r    <= cfg_wdata[8:0];
        rpp_pkg::CFG_TEMPO_MAX: tmax_r    <= cfg_wdata[8:0];
        rpp_pkg::CFG_MIN_STEP:  minstep_r <= cfg_wdata[9:0];
        rpp_pkg::CFG_DEBOUNCE:  deb_r     <= cfg_wdata[9:0];
        rpp_pkg::CFG_GAP:       gap_r     <= cfg_wdata;
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_buzzer      = out_drive_r[0];
  assign out_led_red     = out_drive_r[1];
  assign out_led_yellow  = out_drive_r[2];
  assign out_led_green   = out_drive_r[3];
  assign out_pattern_now = out_sel_r;
  assign out_step_now    = out_pos_r;

endmodule

// ===== hw/rtl/rpp_debounce.sv =====
module rpp_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic                      raw,
  input  logic [rpp_pkg::TIME_W-1:0] t,
  input  logic [9:0]                deb_ms,
  output logic                      press
);

  logic                       stable_r;
  logic                       last_r;
  logic [rpp_pkg::TIME_W-1:0] ct_r;
  logic                       press_r;
  logic [rpp_pkg::TIME_W-1:0] ct_c;
  logic [rpp_pkg::TIME_W-1:0] elapsed_c;
  logic                       fire_c;

  always_comb begin
    ct_c      = (raw != last_r) ? t : ct_r;
    // time running backwards counts as no time gone by
    elapsed_c = (t >= ct_c) ? (t - ct_c) : '0;
    fire_c    = (elapsed_c >= {22'd0, deb_ms}) && (stable_r != raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b1;
      last_r   <= 1'b1;
      ct_r     <= '0;
      press_r  <= 1'b0;
    end else if (upd) begin
      last_r  <= raw;
      ct_r    <= ct_c;
      press_r <= fire_c && !raw;
      if (fire_c) begin
        stable_r <= raw;
      end
    end else begin
      press_r <= 1'b0;
    end
  end

  assign press = press_r;

endmodule

// ===== hw/rtl/rpp_serial_alu.sv =====
module rpp_serial_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rpp_pkg::alu_req_t req,
  output rpp_pkg::alu_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  rpp_pkg::alu_op_t              op_r;
  logic [rpp_pkg::CNT_W-1:0]     cnt_r;
  logic [rpp_pkg::ALU_W-1:0]     acc_r;
  logic [rpp_pkg::ALU_W-1:0]     mcand_r;
  logic [rpp_pkg::MPL_W-1:0]     mplier_r;
  logic [rpp_pkg::DVS_W-1:0]     rem_r;
  logic [rpp_pkg::ALU_W-1:0]     quo_r;
  logic [rpp_pkg::DVS_W-1:0]     dvs_r;
  logic [rpp_pkg::DVS_W+1:0]     try_c;

  // shifted partial remainder minus divisor; top bit set means no subtract
  assign try_c = {1'b0, rem_r, quo_r[rpp_pkg::ALU_W-1]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == rpp_pkg::ALU_MUL) ? rpp_pkg::MUL_STEPS : rpp_pkg::DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r     <= req.op;
      acc_r    <= '0;
      mcand_r  <= req.opa;
      mplier_r <= req.opb[rpp_pkg::MPL_W-1:0];
      rem_r    <= '0;
      quo_r    <= req.opa;
      dvs_r    <= req.opb;
    end else if (busy_r) begin
      if (op_r == rpp_pkg::ALU_MUL) begin
        // one multiplier bit a cycle: add, then shift
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[rpp_pkg::ALU_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[rpp_pkg::MPL_W-1:1]};
      end else begin
        // one quotient bit a cycle, restoring
        if (!try_c[rpp_pkg::DVS_W+1]) begin
          rem_r <= try_c[rpp_pkg::DVS_W-1:0];
          quo_r <= {quo_r[rpp_pkg::ALU_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[rpp_pkg::DVS_W-2:0], quo_r[rpp_pkg::ALU_W-1]};
          quo_r <= {quo_r[rpp_pkg::ALU_W-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == rpp_pkg::ALU_MUL) ? acc_r : quo_r;

endmodule

// ===== bench/rhythm_pattern_player_top_tb.sv =====
`timescale 1ns / 1ps

module rhythm_pattern_player_top_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TUNE_LEN    = 19;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_POLLS = 92;
  localparam int unsigned PRINT_CAP   = 40;
  localparam longint      SLIDER_SPAN = 4095;
  localparam longint      PCT_DIV     = 100;

  // rhythm tables, padded with end markers
  localparam logic [4:0] TUNES [0:2][0:TUNE_LEN-1] = '{
    '{rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON3, rpp_pkg::OFF4,
      rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON3, rpp_pkg::OFF4,
      rpp_pkg::STEP_END, rpp_pkg::STEP_END, rpp_pkg::STEP_END, rpp_pkg::STEP_END,
      rpp_pkg::STEP_END, rpp_pkg::STEP_END, rpp_pkg::STEP_END},
    '{rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF2, rpp_pkg::ON3, rpp_pkg::OFF3,
      rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF2, rpp_pkg::ON3, rpp_pkg::OFF3,
      rpp_pkg::ON1, rpp_pkg::OFF2, rpp_pkg::ON3, rpp_pkg::OFF2, rpp_pkg::ON3, rpp_pkg::OFF4,
      rpp_pkg::STEP_END},
    '{rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF1,
      rpp_pkg::ON3, rpp_pkg::OFF2, rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON1, rpp_pkg::OFF1,
      rpp_pkg::ON1, rpp_pkg::OFF1, rpp_pkg::ON3, rpp_pkg::OFF3,
      rpp_pkg::STEP_END, rpp_pkg::STEP_END, rpp_pkg::STEP_END}
  };

  typedef struct packed {
    logic       buzzer;
    logic       red;
    logic       yellow;
    logic       green;
    logic [1:0] tune;
    logic [4:0] step;
  } levels_t;

  class rhythm_scoreboard;
    logic [9:0]  base_tick;
    logic [8:0]  tempo_min;
    logic [8:0]  tempo_max;
    logic [9:0]  min_step;
    logic [9:0]  debounce;
    logic [13:0] gap;
    logic [1:0]  sel;
    logic [4:0]  pos;
    bit          finished;
    logic [31:0] deadline;
    bit          armed;
    logic [1:0]  phase;
    bit          stable [2];
    bit          prev_level [2];
    logic [31:0] change_t [2];
    logic [3:0]  drive;  // {green, yellow, red, buzzer}
    levels_t     due_levels [$];
    int unsigned errors;

    function new();
      base_tick = rpp_pkg::BASE_TICK_RST;
      tempo_min = rpp_pkg::TEMPO_MIN_RST;
      tempo_max = rpp_pkg::TEMPO_MAX_RST;
      min_step  = rpp_pkg::MIN_STEP_RST;
      debounce  = rpp_pkg::DEBOUNCE_RST;
      gap       = rpp_pkg::GAP_RST;
      start_tune(2'd0);
      for (int b = 0; b < 2; b++) begin
        stable[b]     = 1'b1;
        prev_level[b] = 1'b1;
        change_t[b]   = '0;
      end
      drive  = '0;
      errors = 0;
    endfunction

    function void set_reg(rpp_pkg::cfg_idx_t idx, logic [13:0] v);
      case (idx)
        rpp_pkg::CFG_BASE_TICK: base_tick = v[9:0];
        rpp_pkg::CFG_TEMPO_MIN: tempo_min = v[8:0];
        rpp_pkg::CFG_TEMPO_MAX: tempo_max = v[8:0];
        rpp_pkg::CFG_MIN_STEP:  min_step  = v[9:0];
        rpp_pkg::CFG_DEBOUNCE:  debounce  = v[9:0];
        rpp_pkg::CFG_GAP:       gap       = v;
        default: ;
      endcase
    endfunction

    function void start_tune(logic [1:0] idx);
      if (idx >= rpp_pkg::NUM_PATTERNS) idx = 2'd0;
      sel      = idx;
      pos      = '0;
      finished = 1'b0;
      phase    = '0;
      deadline = '0;
      armed    = 1'b0;
    endfunction

    function bit press_seen(int b, bit raw, logic [31:0] t);
      logic [31:0] held;
      if (raw != prev_level[b]) begin
        prev_level[b] = raw;
        change_t[b]   = t;
      end
      // time running backwards counts as no hold at all
      held = (t >= change_t[b]) ? t - change_t[b] : 32'd0;
      if (held >= debounce && stable[b] != raw) begin
        stable[b] = raw;
        return raw == 1'b0;
      end
      return 1'b0;
    endfunction

    function logic [31:0] sat_deadline(logic [31:0] t, logic [31:0] d);
      logic [32:0] s;
      s = {1'b0, t} + {1'b0, d};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function logic [31:0] step_ms(logic [3:0] units, logic [11:0] slider);
      longint lo, hi, pct, ms;
      lo  = longint'(tempo_min);
      hi  = longint'(tempo_max);
      pct = hi - (longint'(slider) * (hi - lo)) / SLIDER_SPAN;
      // low clamp first, so min above max ends at max
      if (pct < lo) pct = lo;
      if (pct > hi) pct = hi;
      ms = (longint'(units) * longint'(base_tick) * pct) / PCT_DIV;
      if (ms < longint'(min_step)) ms = longint'(min_step);
      return ms[31:0];
    endfunction

    function void run_player(logic [31:0] t, logic [11:0] slider);
      logic [4:0] entry;
      logic [2:0] lights;
      if (finished) begin
        drive = '0;
        if (!armed) begin
          deadline = sat_deadline(t, 32'(gap));
          armed    = 1'b1;
        end else if (t >= deadline) begin
          start_tune(sel);
        end
        return;
      end
      if (armed && t < deadline) return;
      entry = (pos < TUNE_LEN) ? TUNES[sel][pos] : rpp_pkg::STEP_END;
      if (entry[3:0] == 4'd0) begin
        finished = 1'b1;
        deadline = '0;
        armed    = 1'b0;
        drive    = '0;
        return;
      end
      if (entry[4]) begin
        lights = (phase == 2'd3) ? 3'b111 : 3'b001 << phase;
        drive  = {lights, 1'b1};
        phase  = phase + 2'd1;
      end else begin
        drive = '0;
      end
      deadline = sat_deadline(t, step_ms(entry[3:0], slider));
      armed    = 1'b1;
      pos      = pos + 5'd1;
    endfunction

    function void note_poll(logic [31:0] t, logic rr, logic rn, logic [11:0] slider);
      levels_t want;
      if (press_seen(0, rr, t)) start_tune(sel);
      if (press_seen(1, rn, t)) start_tune((sel + 2'd1) % rpp_pkg::NUM_PATTERNS);
      run_player(t, slider);
      want.buzzer = drive[0];
      want.red    = drive[1];
      want.yellow = drive[2];
      want.green  = drive[3];
      want.tune   = sel;
      want.step   = pos;
      due_levels.push_back(want);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_levels(levels_t got);
      levels_t want;
      if (due_levels.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = due_levels.pop_front();
      field_ok("buzzer", want.buzzer, got.buzzer);
      field_ok("led_red", want.red, got.red);
      field_ok("led_yellow", want.yellow, got.yellow);
      field_ok("led_green", want.green, got.green);
      field_ok("pattern_now", want.tune, got.tune);
      field_ok("step_now", want.step, got.step);
    endfunction

    function int unsigned pending();
      return due_levels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_time_now = '0;
  logic        in_raw_restart = 1'b1;
  logic        in_raw_next = 1'b1;
  logic [11:0] in_slider_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_buzzer;
  logic        out_led_red;
  logic        out_led_yellow;
  logic        out_led_green;
  logic [1:0]  out_pattern_now;
  logic [4:0]  out_step_now;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [13:0] cfg_wdata = '0;

  rhythm_scoreboard sb = new();

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned stride = 30;
  int unsigned hold_rs = 0;
  int unsigned hold_nx = 0;
  logic [31:0] t_now = '0;
  logic [13:0] reg_plan [6];

  rhythm_pattern_player_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_time_now     (in_time_now),
    .in_raw_restart  (in_raw_restart),
    .in_raw_next     (in_raw_next),
    .in_slider_sample(in_slider_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_buzzer      (out_buzzer),
    .out_led_red     (out_led_red),
    .out_led_yellow  (out_led_yellow),
    .out_led_green   (out_led_green),
    .out_pattern_now (out_pattern_now),
    .out_step_now    (out_step_now),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : watch_words
    levels_t got;
    got = {out_buzzer, out_led_red, out_led_yellow, out_led_green,
           out_pattern_now, out_step_now};
    if (rst_n && out_valid && out_ready) sb.check_levels(got);
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[rhythm_pattern_player_top] ERROR");
    $finish;
  end

  task automatic send_poll(input logic [31:0] t, input logic rr, input logic rn,
                           input logic [11:0] sl);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_time_now      <= t;
    in_raw_restart   <= rr;
    in_raw_next      <= rn;
    in_slider_sample <= sl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_poll(t, rr, rn, sl);
  endtask

  task automatic random_poll();
    int unsigned roll;
    logic rr, rn;
    logic [11:0] sl;
    roll = $urandom_range(0, 999);
    // mostly steady time; now and then jump anywhere or run up to the top
    if (roll < 8) t_now = $urandom();
    else if (roll < 12) t_now = 32'hFFFF_FFFF - $urandom_range(0, 4 * stride);
    else t_now = t_now + $urandom_range(0, stride);
    if (hold_rs == 0 && $urandom_range(0, 99) < 2) hold_rs = $urandom_range(1, 14);
    if (hold_nx == 0 && $urandom_range(0, 99) < 2) hold_nx = $urandom_range(1, 14);
    rr = (hold_rs == 0);
    rn = (hold_nx == 0);
    if (hold_rs != 0) hold_rs--;
    if (hold_nx != 0) hold_nx--;
    case ($urandom_range(0, 9))
      0: sl = '0;
      1: sl = '1;
      default: sl = 12'($urandom_range(0, 4095));
    endcase
    send_poll(t_now, rr, rn, sl);
  endtask

  // drop valid, let every word come back, then hold the block idle a little
  task automatic drain_words();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_plan();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= rpp_pkg::cfg_idx_t'(i);
      cfg_wdata <= reg_plan[i];
      sb.set_reg(rpp_pkg::cfg_idx_t'(i), reg_plan[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned ph;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 18;
    recv_idle = 70;
    send_poll(32'd0, 1'b1, 1'b1, 12'd0);
    send_poll(32'd0, 1'b0, 1'b1, 12'hFFF);
    send_poll(32'd60, 1'b0, 1'b0, 12'd2048);
    send_poll(32'd120, 1'b1, 1'b0, 12'd0);
    send_poll(32'd200, 1'b1, 1'b1, 12'hFFF);
    send_poll(32'd260, 1'b1, 1'b1, 12'hFFF);
    // both buttons fire on the same poll: replay, then advance
    send_poll(32'd300, 1'b0, 1'b0, 12'd1);
    send_poll(32'd360, 1'b0, 1'b0, 12'd4094);
    send_poll(32'd370, 1'b1, 1'b1, 12'hAAA);
    // time steps backwards
    send_poll(32'd10, 1'b1, 1'b1, 12'h555);
    send_poll(32'd30, 1'b0, 1'b1, 12'd0);
    send_poll(32'd90, 1'b0, 1'b1, 12'd0);
    // deadline saturates at the top of the time range
    send_poll(32'hFFFF_FFC0, 1'b1, 1'b1, 12'd0);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 12'hFFF);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 12'd0);
    send_poll(32'd0, 1'b1, 1'b1, 12'd0);
    send_poll(32'd0, 1'b0, 1'b1, 12'd100);
    send_poll(32'd100, 1'b0, 1'b1, 12'd3000);
    send_poll(32'd200, 1'b1, 1'b1, 12'd500);
    t_now = 32'd200;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle = 18;
          recv_idle = 70;
        end
        1: begin
          send_idle = 70;
          recv_idle = 18;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (ph != 0) begin
        drain_words();
        case (ph)
          1: begin
            reg_plan = '{14'd1, 14'd1, 14'd1, 14'd0, 14'd0, 14'd0};
            stride = 3;
          end
          2: begin
            reg_plan = '{14'd1000, 14'd400, 14'd400, 14'd1000, 14'd1000, 14'd10000};
            stride = 900;
          end
          3: begin
            reg_plan = '{14'd7, 14'd300, 14'd20, 14'd5, 14'd3, 14'd40};
            stride = 15;
          end
          4: begin
            // junk above each narrower register's width must be ignored
            reg_plan[0] = {4'($urandom), 10'($urandom_range(0, 20))};
            reg_plan[1] = {5'($urandom), 9'($urandom_range(0, 400))};
            reg_plan[2] = {5'($urandom), 9'($urandom_range(0, 400))};
            reg_plan[3] = {4'($urandom), 10'($urandom_range(0, 60))};
            reg_plan[4] = {4'($urandom), 10'($urandom_range(0, 40))};
            reg_plan[5] = 14'($urandom_range(0, 300));
            stride = 20;
          end
          default: begin
            reg_plan = '{14'd2, 14'd0, 14'd511, 14'd1023, 14'd1023, 14'h3FFF};
            stride = 1500;
          end
        endcase
        write_plan();
      end
      repeat (PHASE_POLLS) random_poll();
    end

    drain_words();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[rhythm_pattern_player_top] OK");
    end else begin
      $display("[rhythm_pattern_player_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_debounce.sv
hw/rtl/rpp_serial_alu.sv
hw/rtl/rhythm_pattern_player_top.sv
bench/rhythm_pattern_player_top_tb.sv
